>>> hdl/pal_pkg.sv
// Package: shared widths, codes and word types for the pointer axis lock.
`timescale 1ns / 1ps
`default_nettype none
package pal_pkg;

	localparam int unsigned ACC_WIDTH_DEF = 40;
	localparam int unsigned DELTA_W       = 32;
	localparam int unsigned TIME_W        = 63;
	localparam int unsigned CFG_W         = 16;
	localparam int unsigned CFG_IDX_W     = 4;
	localparam int unsigned LOCK_W        = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_THR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_GAP = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] LOCK_THR_RST = CFG_W'(16);
	localparam logic [CFG_W-1:0] IDLE_GAP_RST = CFG_W'(500);

	// lock codes
	localparam logic [LOCK_W-1:0] LOCK_NONE = LOCK_W'(0);
	localparam logic [LOCK_W-1:0] LOCK_X    = LOCK_W'(1);
	localparam logic [LOCK_W-1:0] LOCK_Y    = LOCK_W'(2);

	localparam logic [DELTA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [DELTA_W-1:0] S32_MIN = 32'h8000_0000;

	typedef struct packed {
		logic                      is_motion;
		logic                      axis_is_y;
		logic signed [DELTA_W-1:0] delta;
		logic                      sync;
		logic [TIME_W-1:0]         now_ms;
	} pal_evt_t;

	typedef struct packed {
		logic                      out_axis_is_y;
		logic signed [DELTA_W-1:0] out_delta;
		logic [LOCK_W-1:0]         out_locked;
	} pal_res_t;

	typedef struct packed {
		logic [CFG_W-1:0] lock_thr;
		logic [CFG_W-1:0] idle_gap;
	} pal_cfg_t;

endpackage
`default_nettype wire

>>> hdl/pal_if.sv
// Interfaces: event input, result output and register write channels.
`timescale 1ns / 1ps
`default_nettype none
interface pal_evt_if;
	import pal_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      is_motion;
	logic                      axis_is_y;
	logic signed [DELTA_W-1:0] delta;
	logic                      sync;
	logic [TIME_W-1:0]         now_ms;

	modport source (output valid, is_motion, axis_is_y, delta, sync, now_ms, input ready);
	modport sink (input valid, is_motion, axis_is_y, delta, sync, now_ms, output ready);
endinterface

interface pal_res_if;
	import pal_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      out_axis_is_y;
	logic signed [DELTA_W-1:0] out_delta;
	logic [LOCK_W-1:0]         out_locked;

	modport source (output valid, out_axis_is_y, out_delta, out_locked, input ready);
	modport sink (input valid, out_axis_is_y, out_delta, out_locked, output ready);
endinterface

interface pal_cfg_if;
	import pal_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/pal_cfg_regs.sv
// Configuration registers: threshold and unlock timeout.
`timescale 1ns / 1ps
`default_nettype none
module pal_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	pal_cfg_if.sink           cfg,
	output pal_pkg::pal_cfg_t regs
);
	import pal_pkg::*;

	pal_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.lock_thr <= LOCK_THR_RST;
			regs_q.idle_gap <= IDLE_GAP_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_LOCK_THR: regs_q.lock_thr <= cfg.data;
				REG_IDLE_GAP: regs_q.idle_gap <= cfg.data;
				default: ;  // unknown index, dropped
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/pal_step.sv
// Step logic: timeout, accumulate, axis decision, plus the lock/sum state.
`timescale 1ns / 1ps
`default_nettype none
module pal_step #(
	parameter int unsigned ACC_WIDTH = pal_pkg::ACC_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  pal_pkg::pal_evt_t item,
	input  pal_pkg::pal_cfg_t regs,
	output pal_pkg::pal_res_t result
);
	import pal_pkg::*;

	localparam int unsigned SUM_W = (ACC_WIDTH < 64) ? ACC_WIDTH + 1 : 64;
	localparam logic [ACC_WIDTH-1:0] MAG_TOP = '1;
	localparam logic [ACC_WIDTH-1:0] SUM_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic [ACC_WIDTH-1:0] SUM_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

	// saturating magnitude add
	function automatic logic [ACC_WIDTH-1:0] mag_add(input logic [ACC_WIDTH-1:0] acc,
	                                                  input logic [DELTA_W-1:0] a);
		logic [ACC_WIDTH:0] s;
		s = {1'b0, acc} + (ACC_WIDTH+1)'(a);
		return s[ACC_WIDTH] ? MAG_TOP : s[ACC_WIDTH-1:0];
	endfunction

	// saturating two's complement add
	function automatic logic [ACC_WIDTH-1:0] sum_add(input logic [ACC_WIDTH-1:0] acc,
	                                                  input logic [DELTA_W-1:0] d);
		logic [ACC_WIDTH:0] s;
		s = {acc[ACC_WIDTH-1], acc} + {{(ACC_WIDTH+1-DELTA_W){d[DELTA_W-1]}}, d};
		if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
			return s[ACC_WIDTH] ? SUM_MIN : SUM_MAX;
		return s[ACC_WIDTH-1:0];
	endfunction

	logic [LOCK_W-1:0]    lock_q, lock_d, lk;
	logic [ACC_WIDTH-1:0] xm_q, ym_q, xs_q, ys_q;
	logic [ACC_WIDTH-1:0] xm_d, ym_d, xs_d, ys_d;
	logic [ACC_WIDTH-1:0] xm_c, ym_c, xs_c, ys_c;
	logic [ACC_WIDTH-1:0] xm_a, ym_a, xs_a, ys_a;
	logic [ACC_WIDTH-1:0] sel;
	logic [TIME_W-1:0]    last_q, last_d;
	logic [TIME_W:0]      diff;
	logic [SUM_W-1:0]     tot;
	logic [DELTA_W-1:0]   abs_d;
	logic                 nz, hit, reached, pick_x, fits, on_axis;

	always_comb begin
		nz    = item.delta != '0;
		abs_d = item.delta[DELTA_W-1] ? -item.delta : item.delta;

		// idle-gap release; last time zero means no motion seen yet
		diff = {1'b0, item.now_ms} - {1'b0, last_q};
		hit  = item.is_motion && nz && (last_q != '0) && !diff[TIME_W]
		       && (diff[TIME_W-1:0] >= TIME_W'(regs.idle_gap));

		lk   = hit ? LOCK_NONE : lock_q;
		xm_c = hit ? '0 : xm_q;
		ym_c = hit ? '0 : ym_q;
		xs_c = hit ? '0 : xs_q;
		ys_c = hit ? '0 : ys_q;

		xm_a = (nz && !item.axis_is_y) ? mag_add(xm_c, abs_d) : xm_c;
		xs_a = (nz && !item.axis_is_y) ? sum_add(xs_c, item.delta) : xs_c;
		ym_a = (nz && item.axis_is_y) ? mag_add(ym_c, abs_d) : ym_c;
		ys_a = (nz && item.axis_is_y) ? sum_add(ys_c, item.delta) : ys_c;

		tot     = SUM_W'(xm_a) + SUM_W'(ym_a);
		reached = (xm_a >= ACC_WIDTH'(regs.lock_thr))
		          || (ym_a >= ACC_WIDTH'(regs.lock_thr))
		          || (tot >= SUM_W'(regs.lock_thr));
		pick_x  = xm_a >= ym_a;
		sel     = pick_x ? xs_a : ys_a;
		fits    = (&sel[ACC_WIDTH-1:DELTA_W-1]) || !(|sel[ACC_WIDTH-1:DELTA_W-1]);
		on_axis = ((lk == LOCK_X) && !item.axis_is_y) || ((lk == LOCK_Y) && item.axis_is_y);

		lock_d = lock_q;
		xm_d   = xm_q;
		ym_d   = ym_q;
		xs_d   = xs_q;
		ys_d   = ys_q;
		last_d = last_q;
		result.out_axis_is_y = item.axis_is_y;
		result.out_delta     = item.delta;

		if (item.is_motion) begin
			if (nz)
				last_d = item.now_ms;
			lock_d = lk;
			xm_d   = xm_c;
			ym_d   = ym_c;
			xs_d   = xs_c;
			ys_d   = ys_c;
			if (lk != LOCK_NONE) begin
				if (!on_axis)
					result.out_delta = '0;
			end else if (item.sync && reached) begin
				lock_d = pick_x ? LOCK_X : LOCK_Y;
				result.out_axis_is_y = !pick_x;
				result.out_delta = fits ? sel[DELTA_W-1:0]
				                        : (sel[ACC_WIDTH-1] ? S32_MIN : S32_MAX);
				xm_d = '0;
				ym_d = '0;
				xs_d = '0;
				ys_d = '0;
			end else begin
				xm_d = xm_a;
				ym_d = ym_a;
				xs_d = xs_a;
				ys_d = ys_a;
				result.out_delta = '0;
			end
		end
		result.out_locked = lock_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q <= LOCK_NONE;
			xm_q   <= '0;
			ym_q   <= '0;
			xs_q   <= '0;
			ys_q   <= '0;
			last_q <= '0;
		end else if (advance) begin
			lock_q <= lock_d;
			xm_q   <= xm_d;
			ym_q   <= ym_d;
			xs_q   <= xs_d;
			ys_q   <= ys_d;
			last_q <= last_d;
		end
	end

endmodule
`default_nettype wire

>>> hdl/pointer_axis_lock.sv
// Top level: single-axis lock for relative pointer motion words.
// The result is registered: an accepted event passes the input register, then the result register.
// One word per cycle while the result sink does not stall; the lock/accumulator update is combinational.
// The result register frees the input side while a result waits to be taken.
// Reset (arst_n low): lock none, sums and last motion time zero, threshold 16,
// timeout 500 ms, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none
module pointer_axis_lock #(
	parameter int unsigned ACC_WIDTH = pal_pkg::ACC_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	pal_cfg_if.sink  cfg,
	pal_evt_if.sink  evt,
	pal_res_if.source res
);
	import pal_pkg::*;

	pal_cfg_t regs;
	pal_evt_t evt_s1;     // input stage word
	logic     v_s1;
	logic     adv_s1;     // stage 1 word moves into the result register
	pal_res_t step_res;
	pal_res_t res_q;
	logic     res_valid_q;

	// register block
	pal_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// stage 1 advances when the result register is empty or being drained
	assign adv_s1    = v_s1 && (!res_valid_q || res.ready);
	assign evt.ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (evt.ready) begin
			v_s1 <= evt.valid;
		end
	end

	// input payload, no reset needed
	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1.is_motion <= evt.is_motion;
			evt_s1.axis_is_y <= evt.axis_is_y;
			evt_s1.delta     <= evt.delta;
			evt_s1.sync      <= evt.sync;
			evt_s1.now_ms    <= evt.now_ms;
		end
	end

	// state update happens exactly when the word leaves stage 1
	pal_step #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (adv_s1),
		.item    (evt_s1),
		.regs    (regs),
		.result  (step_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= step_res;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.out_axis_is_y = res_q.out_axis_is_y;
	assign res.out_delta     = res_q.out_delta;
	assign res.out_locked    = res_q.out_locked;

	// an accepted word always lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.ready |=> v_s1)
		else $error("accepted word missing from stage 1");

	// a word leaving stage 1 always shows up as a result
	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> res.valid)
		else $error("stage 1 word lost on the way to the result register");

	// full pipe with a stalled result must refuse input
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && res.valid && !res.ready |-> !evt.ready)
		else $error("input taken while pipe is full");

	// a held stage 1 word keeps its payload
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv_s1 |=> v_s1 && $stable(evt_s1))
		else $error("stage 1 word changed while stalled");

endmodule
`default_nettype wire

>>> tb/tb_pointer_axis_lock.sv
// Testbench for pointer_axis_lock: directed, saturation and random frame tests.
`timescale 1ns / 1ps
module tb_pointer_axis_lock;
	import pal_pkg::*;

	// Predictor widths follow the block's default accumulator size.
	localparam int unsigned ACC_W = ACC_WIDTH_DEF;
	localparam logic [63:0] MAG_TOP = (64'd1 << ACC_W) - 64'd1;
	localparam longint NET_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
	localparam longint NET_MIN = -NET_MAX - 1;

	// Indexes with no register behind them; writes must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = {CFG_IDX_W{1'b1}};

	logic clk = 1'b0;
	logic arst_n;

	pal_cfg_if cfg ();
	pal_evt_if evt ();
	pal_res_if res ();

	pointer_axis_lock dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.evt(evt),
		.res(res)
	);

	always #5 clk = ~clk;

	// Predictor copy of the block state and registers (reset values).
	logic [LOCK_W-1:0] lock_axis = LOCK_NONE;
	logic [63:0]       x_mag = '0;
	logic [63:0]       y_mag = '0;
	longint            x_net = 0;
	longint            y_net = 0;
	logic [TIME_W-1:0] last_motion_ms = '0;
	logic [CFG_W-1:0]  thr_cfg = LOCK_THR_RST;
	logic [CFG_W-1:0]  tmo_cfg = IDLE_GAP_RST;

	// Result words the block still owes, oldest first.
	pal_res_t lock_words_due[$];

	int src_idle_pct = 0;    // chance per cycle that the event source holds off
	int snk_stall_pct = 0;   // chance per cycle that the result sink stalls
	int events_sent = 0;
	int word_count = 0;
	int mismatch_count = 0;
	logic [TIME_W-1:0] clock_ms;   // running uptime for random frames

	pal_res_t got_word;
	pal_res_t want_word;

	// ---------------------------------------------------------------
	// Predictor helpers
	// ---------------------------------------------------------------
	function automatic logic [63:0] mag_sat(input logic [63:0] acc, input logic [63:0] a);
		if (a > MAG_TOP - acc)
			return MAG_TOP;
		return acc + a;
	endfunction

	function automatic longint net_sat(input longint acc, input longint d);
		if (d > 0 && acc > NET_MAX - d)
			return NET_MAX;
		if (d < 0 && acc < NET_MIN - d)
			return NET_MIN;
		return acc + d;
	endfunction

	function automatic longint clamp_word(input longint v);
		longint hi;
		longint lo;
		hi = longint'($signed(S32_MAX));
		lo = longint'($signed(S32_MIN));
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	task automatic clear_sums();
		x_mag = '0;
		y_mag = '0;
		x_net = 0;
		y_net = 0;
	endtask

	// One accepted event: update the lock state and queue the word it yields.
	task automatic axis_lock_step(input pal_evt_t e);
		longint d;
		longint out_v;
		logic [63:0] a;
		logic is_y;
		logic on_axis;
		logic reached;
		logic pick_x;
		pal_res_t r;
		d = longint'($signed(e.delta));
		is_y = e.axis_is_y;
		out_v = d;
		if (e.is_motion) begin
			if (d != 0) begin
				// zero last time means no motion seen yet: no timeout possible
				if (last_motion_ms != '0 && e.now_ms >= last_motion_ms &&
						(e.now_ms - last_motion_ms) >= TIME_W'(tmo_cfg)) begin
					lock_axis = LOCK_NONE;
					clear_sums();
				end
				last_motion_ms = e.now_ms;
			end
			if (lock_axis != LOCK_NONE) begin
				on_axis = (lock_axis == LOCK_X && !is_y) || (lock_axis == LOCK_Y && is_y);
				if (!on_axis)
					out_v = 0;
			end else begin
				if (d != 0) begin
					a = (d < 0) ? 64'(-d) : 64'(d);
					if (is_y) begin
						y_mag = mag_sat(y_mag, a);
						y_net = net_sat(y_net, d);
					end else begin
						x_mag = mag_sat(x_mag, a);
						x_net = net_sat(x_net, d);
					end
				end
				reached = x_mag >= 64'(thr_cfg) || y_mag >= 64'(thr_cfg) ||
					(x_mag + y_mag) >= 64'(thr_cfg);
				if (!e.sync || !reached) begin
					out_v = 0;
				end else begin
					pick_x = x_mag >= y_mag;   // X wins ties
					lock_axis = pick_x ? LOCK_X : LOCK_Y;
					is_y = !pick_x;
					out_v = clamp_word(pick_x ? x_net : y_net);
					clear_sums();
				end
			end
		end
		r.out_axis_is_y = is_y;
		r.out_delta = out_v[DELTA_W-1:0];
		r.out_locked = lock_axis;
		lock_words_due.push_back(r);
	endtask

	// ---------------------------------------------------------------
	// Drivers: inputs move on the falling edge, handshakes sampled on the rising
	// ---------------------------------------------------------------
	function automatic pal_evt_t mk_event(input logic m, input logic y,
			input logic signed [DELTA_W-1:0] d, input logic s, input logic [TIME_W-1:0] t);
		pal_evt_t e;
		e.is_motion = m;
		e.axis_is_y = y;
		e.delta = d;
		e.sync = s;
		e.now_ms = t;
		return e;
	endfunction

	// Leaves valid high after the accept; the next call drives its own word, or hold_events lowers it.
	task automatic send_event(input pal_evt_t e);
		@(negedge clk);
		if ($urandom_range(99) < src_idle_pct) begin
			evt.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		evt.valid <= 1'b1;
		evt.is_motion <= e.is_motion;
		evt.axis_is_y <= e.axis_is_y;
		evt.delta <= e.delta;
		evt.sync <= e.sync;
		evt.now_ms <= e.now_ms;
		do @(posedge clk); while (!evt.ready);
		axis_lock_step(e);
		events_sent++;
	endtask

	task automatic hold_events();
		@(negedge clk);
		evt.valid <= 1'b0;
	endtask

	task automatic drain();
		while (lock_words_due.size() != 0)
			@(posedge clk);
	endtask

	// Block idle: events held off, no word in flight, pipeline given spare cycles.
	task automatic quiesce();
		hold_events();
		drain();
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		if (idx == REG_LOCK_THR)
			thr_cfg = val;
		else if (idx == REG_IDLE_GAP)
			tmo_cfg = val;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Result sink: random stalls per cycle.
	always @(negedge clk) begin
		res.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// ---------------------------------------------------------------
	// Result checker
	// ---------------------------------------------------------------
	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at word %0d: %s", word_count, msg);
	endtask

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			got_word.out_axis_is_y = res.out_axis_is_y;
			got_word.out_delta = res.out_delta;
			got_word.out_locked = res.out_locked;
			if (lock_words_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected word axis %0d delta %0d lock %0d",
					got_word.out_axis_is_y, got_word.out_delta, got_word.out_locked));
			end else begin
				want_word = lock_words_due.pop_front();
				if (got_word.out_axis_is_y !== want_word.out_axis_is_y)
					flag_mismatch($sformatf("axis expected %0d got %0d",
						want_word.out_axis_is_y, got_word.out_axis_is_y));
				if (got_word.out_delta !== want_word.out_delta)
					flag_mismatch($sformatf("delta expected %0d got %0d",
						want_word.out_delta, got_word.out_delta));
				if (got_word.out_locked !== want_word.out_locked)
					flag_mismatch($sformatf("lock expected %0d got %0d",
						want_word.out_locked, got_word.out_locked));
			end
			word_count++;
		end
	end

	// ---------------------------------------------------------------
	// Random content
	// ---------------------------------------------------------------
	// Mostly small motion, some wide values, zeros and near-extremes.
	function automatic logic signed [DELTA_W-1:0] pick_delta();
		int unsigned sel;
		logic signed [DELTA_W-1:0] v;
		sel = $urandom_range(99);
		if (sel < 55)
			v = $urandom_range(64, 1);
		else if (sel < 70)
			v = $urandom_range(65535, 1);
		else if (sel < 80)
			v = $urandom;
		else if (sel < 90)
			v = 0;
		else if ($urandom_range(1))
			v = S32_MAX - $urandom_range(3);
		else
			v = S32_MIN + $urandom_range(3);
		if (sel < 70 && $urandom_range(1))
			v = -v;
		return v;
	endfunction

	// One report frame: motion words ending in sync; a few frames are broken.
	task automatic send_frame();
		int n;
		int i;
		logic dom;
		logic broken;
		pal_evt_t e;
		n = $urandom_range(6, 1);
		dom = $urandom_range(1);
		broken = ($urandom_range(99) < 10);
		for (i = 0; i < n; i++) begin
			e.is_motion = 1'b1;
			e.axis_is_y = ($urandom_range(99) < 75) ? dom : !dom;
			e.delta = pick_delta();
			e.sync = (i == n - 1) ? !broken : ($urandom_range(99) < 8);
			e.now_ms = clock_ms;
			send_event(e);
			clock_ms = clock_ms + TIME_W'($urandom_range(2));
		end
	endtask

	// Stray words: passthrough with wild fields, lone motion, motion at any time.
	task automatic send_noise();
		int unsigned sel;
		pal_evt_t e;
		sel = $urandom_range(2);
		e.is_motion = (sel != 0);
		e.axis_is_y = $urandom_range(1);
		e.delta = (sel == 1) ? pick_delta() : $urandom;
		e.sync = $urandom_range(1);
		e.now_ms = (sel == 1) ? clock_ms : TIME_W'({$urandom, $urandom});
		send_event(e);
	endtask

	// Gap between frames: within timeout, past it, backwards or none.
	task automatic advance_clock();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 65)
			clock_ms = clock_ms + TIME_W'($urandom_range(tmo_cfg / 2));
		else if (sel < 85)
			clock_ms = clock_ms + TIME_W'(tmo_cfg) + TIME_W'($urandom_range(50));
		else if (sel < 93 && clock_ms > 100)
			clock_ms = clock_ms - TIME_W'($urandom_range(100));
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// Field extremes, reset registers, lock rules and the corner cases.
	task automatic test_directed();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		// passthrough at both field extremes
		send_event(mk_event(0, 1, S32_MAX, 1, {TIME_W{1'b1}}));
		send_event(mk_event(0, 0, S32_MIN, 0, '0));
		// zero sums, reset threshold of 16 not reached
		send_event(mk_event(1, 0, 0, 1, '0));
		quiesce();
		write_reg(REG_LOCK_THR, '0);
		// threshold zero with all-zero sums: tie goes to X
		send_event(mk_event(1, 1, 0, 1, '0));
		quiesce();
		write_reg(REG_LOCK_THR, LOCK_THR_RST);
		// motion at time zero keeps "no motion yet"
		send_event(mk_event(1, 0, 10, 0, '0));
		send_event(mk_event(1, 1, 4, 0, 700));
		// time going backwards: no timeout, time still taken
		send_event(mk_event(1, 1, 9, 0, 300));
		// zero motion skips the timeout check
		send_event(mk_event(1, 0, 0, 0, 5000));
		send_event(mk_event(1, 1, 3, 0, 799));
		// gap of exactly the reset timeout releases the lock
		send_event(mk_event(1, 0, -6, 0, 1299));
		send_event(mk_event(1, 1, -12, 1, 1300));
		send_event(mk_event(0, 0, -77, 1, 1300));
		send_event(mk_event(1, 0, S32_MAX, 0, {TIME_W{1'b1}}));
		send_event(mk_event(1, 1, S32_MIN, 1, {TIME_W{1'b1}}));
		send_event(mk_event(1, 0, 8, 0, '0));
		quiesce();
		write_reg(REG_LOCK_THR, 5);
		write_reg(REG_IDLE_GAP, '0);
		write_reg(REG_UNUSED_LO, CFG_W'($urandom));
		write_reg(REG_UNUSED_HI, CFG_W'($urandom));
		// timeout zero: every nonzero motion after a prior one releases
		send_event(mk_event(1, 0, 3, 0, 20));
		send_event(mk_event(1, 1, 5, 0, 20));
		send_event(mk_event(1, 0, 5, 1, 21));
		quiesce();
		write_reg(REG_LOCK_THR, {CFG_W{1'b1}});
		write_reg(REG_IDLE_GAP, {CFG_W{1'b1}});
		send_event(mk_event(1, 0, 100, 0, 30));
		send_event(mk_event(1, 1, -40000, 0, 70000));
		// equal magnitudes on both axes: X wins
		send_event(mk_event(1, 0, 40000, 1, 70001));
		send_event(mk_event(1, 1, 1, 1, 70002));
	endtask

	// Drive X net past the top, back down, and X magnitude past full scale.
	// Net saturation shows as a small result instead of a clamped one.
	task automatic test_accumulator_saturation();
		int i;
		logic [TIME_W-1:0] t;
		logic signed [DELTA_W-1:0] d;
		quiesce();
		src_idle_pct = 22;
		snk_stall_pct = 22;
		write_reg(REG_LOCK_THR, {CFG_W{1'b1}});
		write_reg(REG_IDLE_GAP, 1000);
		t = TIME_W'(5_000_000);   // far past the last motion: lock released
		for (i = 0; i < 513; i++) begin
			if ($urandom_range(79) == 0) begin
				d = $urandom_range(1_000_000_000, 1);
				send_event(mk_event(1, 1, $urandom_range(1) ? d : -d, 0, t));
			end
			send_event(mk_event(1, 0, (i < 257) ? S32_MAX : S32_MIN, 0, t));
		end
		send_event(mk_event(1, 0, 0, 1, t));
		send_event(mk_event(1, 1, 7, 0, t));
	endtask

	// Random frames with noise under each idle pattern and register setting.
	task automatic test_random_frames();
		int phase;
		int target;
		for (phase = 0; phase < 4; phase++) begin
			quiesce();
			case (phase)
				0: begin
					src_idle_pct = 0;
					snk_stall_pct = 0;
					write_reg(REG_LOCK_THR, 1);
					write_reg(REG_IDLE_GAP, {CFG_W{1'b1}});
				end
				1: begin
					src_idle_pct = 58;
					snk_stall_pct = 0;
					write_reg(REG_LOCK_THR, $urandom_range(200, 8));
					write_reg(REG_IDLE_GAP, $urandom_range(400, 20));
				end
				2: begin
					src_idle_pct = 0;
					snk_stall_pct = 58;
					write_reg(REG_LOCK_THR, {CFG_W{1'b1}});
					write_reg(REG_IDLE_GAP, 1);
				end
				default: begin
					src_idle_pct = 22;
					snk_stall_pct = 22;
					write_reg(REG_LOCK_THR, $urandom_range(65535, 1));
					write_reg(REG_IDLE_GAP, $urandom_range(2000, 1));
				end
			endcase
			clock_ms = TIME_W'(1000 + $urandom_range(100000));
			target = events_sent + 125;
			while (events_sent < target) begin
				// now and then the source waits for every owed word
				if ($urandom_range(99) < 4) begin
					hold_events();
					drain();
				end
				if ($urandom_range(99) < 80)
					send_frame();
				else
					send_noise();
				advance_clock();
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		evt.valid = 1'b0;
		evt.is_motion = 1'b0;
		evt.axis_is_y = 1'b0;
		evt.delta = '0;
		evt.sync = 1'b0;
		evt.now_ms = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		res.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_accumulator_saturation();
		test_random_frames();

		hold_events();
		drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
